@@ rtl/atp_pkg.sv @@
// Shared types and constants for the AT command line parser.
// No dependencies.
`timescale 1ns / 1ps
package atp_pkg;

  // Result kinds on the output channel
  typedef enum logic [3:0] {
    K_OK           = 4'd0,
    K_REBOOT       = 4'd1,
    K_REBOOT_HELP  = 4'd2,
    K_FACTORY      = 4'd3,
    K_FACTORY_HELP = 4'd4,
    K_ERROR        = 4'd5,
    K_OVERFLOW     = 4'd6,
    K_COMMAND      = 4'd7,
    K_PAYLOAD      = 4'd8,
    K_DROPPED      = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    OP_RUN   = 2'd0,
    OP_HELP  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PART_NONE = 2'd0,
    PART_NAME = 2'd1,
    PART_ARG  = 2'd2
  } part_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_DAT,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_DAT
  } state_t;

  // Event passed from front to back; K_COMMAND marks a line to classify
  typedef struct packed {
    kind_t       kind;
    logic [5:0]  count;
  } evt_t;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_R     = 8'h52;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

@@ rtl/atp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module atp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/atp_fifo.sv @@
// Small event queue between the line editor and the classifier.
// Uses atp_pkg for the event type.
`timescale 1ns / 1ps
module atp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  atp_pkg::evt_t din,
  output logic          full,
  input  logic          pop,
  output atp_pkg::evt_t dout,
  output logic          empty
);
  import atp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  evt_t           mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CW-1:0]  fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = mem[rptr];

  // Store event
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= din;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/atp_front.sv @@
// Line editor: accepts received bytes, keeps the line buffer and queues events.
// Uses atp_pkg; writes the line RAM and pushes into atp_fifo.
`timescale 1ns / 1ps
module atp_front #(
  parameter int LINE_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      rx_byte,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            ram_we,
  output logic [$clog2(LINE_MAX-1)-1:0]   ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            evt_push,
  output atp_pkg::evt_t                   evt,
  input  logic                            evt_full,
  input  logic                            job_done
);
  import atp_pkg::*;

  localparam int DEPTH = LINE_MAX - 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(LINE_MAX);

  logic [CW-1:0] char_count, char_count_next;
  logic          overflow, overflow_next;
  logic          skip_lf, skip_lf_next;
  logic          busy, busy_next;
  logic          accept;
  logic          is_lf, is_cr, is_bs, is_print;

  assign in_stall = evt_full || busy;
  assign accept   = in_valid && !in_stall;

  assign is_lf    = (rx_byte == CH_LF);
  assign is_cr    = (rx_byte == CH_CR);
  assign is_bs    = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  assign is_print = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);

  assign ram_waddr = char_count[AW-1:0];
  assign ram_wdata = rx_byte;

  // Edit the line for each accepted beat
  always_comb begin
    char_count_next = char_count;
    overflow_next   = overflow;
    skip_lf_next    = skip_lf;
    busy_next       = busy;
    ram_we          = 1'b0;
    evt_push        = 1'b0;
    evt.kind        = K_DROPPED;
    evt.count       = 6'(char_count);
    if (job_done) begin
      busy_next = 1'b0;
    end
    if (accept) begin
      skip_lf_next = is_cr;
      if (is_lf && skip_lf) begin
        skip_lf_next = 1'b0;
      end else if (is_bs) begin
        if (char_count != '0) begin
          char_count_next = char_count - 1'b1;
        end
      end else if (is_cr || is_lf) begin
        if (overflow) begin
          overflow_next   = 1'b0;
          char_count_next = '0;
          evt_push        = 1'b1;
          evt.kind        = K_OVERFLOW;
        end else if (char_count != '0) begin
          char_count_next = '0;
          busy_next       = 1'b1;
          evt_push        = 1'b1;
          evt.kind        = K_COMMAND;
        end
      end else if (is_print) begin
        if (char_count >= CW'(DEPTH)) begin
          overflow_next = 1'b1;
          evt_push      = 1'b1;
          evt.kind      = K_DROPPED;
        end else begin
          ram_we          = 1'b1;
          char_count_next = char_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      overflow   <= 1'b0;
      skip_lf    <= 1'b0;
      busy       <= 1'b0;
    end else begin
      char_count <= char_count_next;
      overflow   <= overflow_next;
      skip_lf    <= skip_lf_next;
      busy       <= busy_next;
    end
  end

endmodule

@@ rtl/atp_back.sv @@
// Classifier: scans a finished line from the RAM and emits the result beats.
// Uses atp_pkg; pops atp_fifo and reads the line RAM.
`timescale 1ns / 1ps
module atp_back #(
  parameter int LINE_MAX = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            evt_empty,
  input  atp_pkg::evt_t                   evt,
  output logic                            evt_pop,
  output logic [$clog2(LINE_MAX-1)-1:0]   ram_raddr,
  input  logic [7:0]                      ram_rdata,
  output logic                            job_done,
  output logic [3:0]                      kind,
  output logic [1:0]                      operation,
  output logic [5:0]                      name_length,
  output logic [5:0]                      argument_length,
  output logic [7:0]                      payload_byte,
  output logic [1:0]                      payload_part,
  output logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall
);
  import atp_pkg::*;

  localparam int AW  = $clog2(LINE_MAX - 1);
  localparam int CW  = $clog2(LINE_MAX);
  localparam int CW1 = CW + 1;

  state_t         state, state_next;
  logic [CW1-1:0] idx;
  logic [CW1-1:0] cnt;
  logic [7:0]     chars [4];
  logic           found;
  logic [CW1-1:0] sep;
  logic           sep_q;
  logic           q_after;
  op_t            op;
  logic [CW1-1:0] endi;

  logic           out_free;
  logic           is_job;
  logic           scan_end;
  logic [7:0]     up_byte;
  logic [CW1-1:0] nxt;
  logic           emit_end;

  // Decision from the scan
  logic           dec_single;
  kind_t          dec_kind;
  op_t            dec_op;
  logic           is_at;

  // Output register load
  logic           ld;
  kind_t          ld_kind;
  op_t            ld_op;
  logic [5:0]     ld_nl;
  logic [5:0]     ld_al;
  logic [7:0]     ld_byte;
  part_t          ld_part;
  logic           ld_last;

  assign out_free  = !out_valid || !out_stall;
  assign is_job    = (evt.kind == K_COMMAND);
  assign ram_raddr = idx[AW-1:0];
  assign scan_end  = (idx + 1'b1 == cnt);
  assign up_byte   = to_upper(ram_rdata);

  // Next payload index, stepping over the separator of a write
  always_comb begin
    nxt = idx + 1'b1;
    if (op == OP_WRITE && nxt == sep) begin
      nxt = nxt + 1'b1;
    end
    emit_end = (nxt >= endi);
  end

  // Classify the scanned line
  always_comb begin
    is_at      = (chars[0] == CH_A) && (chars[1] == CH_T);
    dec_single = 1'b1;
    dec_kind   = K_ERROR;
    dec_op     = OP_RUN;
    if (cnt == CW1'(2) && is_at) begin
      dec_kind = K_OK;
    end else if (cnt == CW1'(3) && is_at && chars[2] == CH_Z) begin
      dec_kind = K_REBOOT;
    end else if (cnt == CW1'(4) && is_at && chars[2] == CH_Z && chars[3] == CH_QM) begin
      dec_kind = K_REBOOT_HELP;
    end else if (cnt == CW1'(3) && is_at && chars[2] == CH_R) begin
      dec_kind = K_FACTORY;
    end else if (cnt == CW1'(4) && is_at && chars[2] == CH_R && chars[3] == CH_QM) begin
      dec_kind = K_FACTORY_HELP;
    end else if (cnt >= CW1'(3) && is_at && chars[2] == CH_PLUS) begin
      dec_kind   = K_COMMAND;
      dec_single = 1'b0;
      if (!found) begin
        dec_op = OP_RUN;
      end else if (sep_q && sep + 1'b1 == cnt) begin
        dec_op = OP_HELP;
      end else if (!sep_q && sep + 2'd2 == cnt && q_after) begin
        dec_op = OP_READ;
      end else if (!sep_q && sep + 1'b1 < cnt && !q_after) begin
        dec_op = OP_WRITE;
      end else begin
        dec_kind   = K_ERROR;
        dec_single = 1'b1;
      end
      if (sep == CW1'(3)) begin
        dec_kind   = K_ERROR;
        dec_single = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!evt_empty && is_job) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_DAT;
      ST_SCAN_DAT: state_next = scan_end ? ST_DECIDE : ST_SCAN_RD;
      ST_DECIDE: begin
        if (out_free) begin
          state_next = dec_single ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT_DAT;
      ST_EMIT_DAT: begin
        if (out_free) begin
          state_next = emit_end ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    evt_pop  = 1'b0;
    job_done = 1'b0;
    ld       = 1'b0;
    ld_kind  = K_OK;
    ld_op    = OP_RUN;
    ld_nl    = '0;
    ld_al    = '0;
    ld_byte  = '0;
    ld_part  = PART_NONE;
    ld_last  = 1'b1;
    case (state)
      ST_IDLE: begin
        if (!evt_empty && (is_job || out_free)) begin
          evt_pop = 1'b1;
          if (!is_job) begin
            ld      = 1'b1;
            ld_kind = evt.kind;
          end
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = dec_kind;
          job_done = dec_single;
          if (!dec_single) begin
            ld_op   = dec_op;
            ld_nl   = 6'(sep) - 6'd3;
            ld_al   = (dec_op == OP_WRITE) ? 6'(cnt - sep - 1'b1) : 6'd0;
            ld_last = 1'b0;
          end
        end
      end
      ST_EMIT_DAT: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_kind  = K_PAYLOAD;
          ld_part  = (idx < sep) ? PART_NAME : PART_ARG;
          ld_byte  = (idx < sep) ? up_byte : ram_rdata;
          ld_last  = emit_end;
          job_done = emit_end;
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  // Scan and emit registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx     <= '0;
        cnt     <= CW1'(evt.count);
        sep     <= CW1'(evt.count);
        found   <= 1'b0;
        sep_q   <= 1'b0;
        q_after <= 1'b0;
      end
      ST_SCAN_DAT: begin
        if (idx < CW1'(4)) begin
          chars[idx[1:0]] <= up_byte;
        end
        if (idx >= CW1'(3)) begin
          if (!found && (ram_rdata == CH_EQ || ram_rdata == CH_QM)) begin
            found <= 1'b1;
            sep   <= idx;
            sep_q <= (ram_rdata == CH_QM);
          end else if (found && ram_rdata == CH_QM) begin
            q_after <= 1'b1;
          end
        end
        if (!scan_end) begin
          idx <= idx + 1'b1;
        end
      end
      ST_DECIDE: begin
        op   <= dec_op;
        endi <= (dec_op == OP_WRITE) ? cnt : sep;
        idx  <= CW1'(3);
      end
      ST_EMIT_DAT: begin
        if (out_free) begin
          idx <= nxt;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (ld) begin
      kind            <= ld_kind;
      operation       <= ld_op;
      name_length     <= ld_nl;
      argument_length <= ld_al;
      payload_byte    <= ld_byte;
      payload_part    <= ld_part;
      last            <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/at_command_line_parser.sv @@
// Top level of the AT command line parser.
// Plain bytes are accepted back to back while input is not stalled; a line end with
// stored bytes blocks input while the line is scanned and its payload beats are emitted.
// Throughput is set by the single read port of the line RAM.
// Synchronous active-high reset clears counts, flags, queue and output valid.
`timescale 1ns / 1ps
module at_command_line_parser #(
  parameter int LINE_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [3:0] kind,
  output logic [1:0] operation,
  output logic [5:0] name_length,
  output logic [5:0] argument_length,
  output logic [7:0] payload_byte,
  output logic [1:0] payload_part,
  output logic       last,
  output logic       out_valid,
  input  logic       out_stall
);
  import atp_pkg::*;

  localparam int DEPTH = LINE_MAX - 1;
  localparam int AW    = $clog2(DEPTH);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          evt_push, evt_pop, evt_full, evt_empty;
  evt_t          evt_in, evt_out;
  logic          job_done;

  atp_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .evt_push  (evt_push),
    .evt       (evt_in),
    .evt_full  (evt_full),
    .job_done  (job_done)
  );

  atp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  atp_fifo #(.DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (evt_push),
    .din   (evt_in),
    .full  (evt_full),
    .pop   (evt_pop),
    .dout  (evt_out),
    .empty (evt_empty)
  );

  atp_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk             (clk),
    .rst             (rst),
    .evt_empty       (evt_empty),
    .evt             (evt_out),
    .evt_pop         (evt_pop),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .job_done        (job_done),
    .kind            (kind),
    .operation       (operation),
    .name_length     (name_length),
    .argument_length (argument_length),
    .payload_byte    (payload_byte),
    .payload_part    (payload_part),
    .last            (last),
    .out_valid       (out_valid),
    .out_stall       (out_stall)
  );

endmodule

@@ test/at_command_line_parser_test.sv @@
// Testbench for the AT command line parser: a scoreboard class predicts the
// results of every accepted byte, plain tasks drive the block and an always block stalls it.
// Depends on atp_pkg and at_command_line_parser.
`timescale 1ns / 1ps
module at_command_line_parser_test;
  import atp_pkg::*;

  localparam int LINE_LEN  = 64;
  localparam int STORE_LEN = LINE_LEN - 1;
  localparam int LIMIT     = 1000000;

  typedef struct packed {
    kind_t      kind;
    op_t        operation;
    logic [5:0] name_length;
    logic [5:0] argument_length;
    logic [7:0] payload_byte;
    part_t      payload_part;
    logic       last;
  } result_t;

  int errors = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Line predictor and queue of expected results
  class line_scoreboard;
    logic [7:0] line_buf[STORE_LEN];
    int         count;
    bit         overflowed;
    bit         skip_lf;
    result_t    pending[$];
    int         n_lines, n_results;

    function void clear();
      count = 0; overflowed = 0; skip_lf = 0; pending.delete();
    endfunction

    function logic [7:0] up(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function bit same_ci(input string s);
      if (count != s.len()) return 0;
      for (int i = 0; i < s.len(); i++)
        if (up(line_buf[i]) != up(s[i])) return 0;
      return 1;
    endfunction

    function void push(input kind_t k, input op_t o = OP_RUN, input int nl = 0,
                       input int al = 0, input logic [7:0] b = 0,
                       input part_t p = PART_NONE);
      result_t r;
      r = '{k, o, nl[5:0], al[5:0], b, p, 1'b0};
      pending.push_back(r);
    endfunction

    function void classify_line();
      int sep, arg_start, arg_len;
      op_t o;
      arg_start = 0; arg_len = 0;
      if (same_ci("AT")) begin push(K_OK); return; end
      if (same_ci("ATZ")) begin push(K_REBOOT); return; end
      if (same_ci("ATZ?")) begin push(K_REBOOT_HELP); return; end
      if (same_ci("ATR")) begin push(K_FACTORY); return; end
      if (same_ci("ATR?")) begin push(K_FACTORY_HELP); return; end
      if (count < 3 || up(line_buf[0]) != CH_A || up(line_buf[1]) != CH_T ||
          line_buf[2] != CH_PLUS) begin
        push(K_ERROR); return;
      end
      sep = 3;
      while (sep < count && line_buf[sep] != CH_EQ && line_buf[sep] != CH_QM) sep++;
      if (sep >= count) o = OP_RUN;
      else if (line_buf[sep] == CH_QM && sep + 1 == count) o = OP_HELP;
      else if (line_buf[sep] == CH_EQ && sep + 2 == count && line_buf[sep+1] == CH_QM)
        o = OP_READ;
      else if (line_buf[sep] == CH_EQ && sep + 1 < count) begin
        for (int i = sep + 1; i < count; i++)
          if (line_buf[i] == CH_QM) begin push(K_ERROR); return; end
        o = OP_WRITE; arg_start = sep + 1; arg_len = count - arg_start;
      end else begin
        push(K_ERROR); return;
      end
      if (sep == 3) begin push(K_ERROR); return; end
      push(K_COMMAND, o, sep - 3, arg_len);
      for (int i = 3; i < sep; i++) push(K_PAYLOAD, OP_RUN, 0, 0, up(line_buf[i]), PART_NAME);
      for (int i = 0; i < arg_len; i++)
        push(K_PAYLOAD, OP_RUN, 0, 0, line_buf[arg_start+i], PART_ARG);
    endfunction

    // Note one accepted input beat
    function void note_byte(input logic [7:0] b);
      int n_before;
      n_before = pending.size();
      if (b == CH_LF && skip_lf) begin skip_lf = 0; return; end
      skip_lf = 0;
      if (b == CH_BS || b == CH_DEL) begin
        if (count != 0) count--;
        return;
      end
      if (b == CH_CR || b == CH_LF) begin
        skip_lf = (b == CH_CR);
        if (overflowed) begin
          overflowed = 0; count = 0; push(K_OVERFLOW);
        end else if (count != 0) begin
          classify_line(); count = 0;
        end
        n_lines++;
      end else if (b < CH_SPACE || b > CH_TILDE) begin
        return;
      end else if (count >= STORE_LEN) begin
        overflowed = 1; push(K_DROPPED);
      end else begin
        line_buf[count] = b; count++;
      end
      if (pending.size() > n_before) pending[pending.size()-1].last = 1'b1;
    endfunction

    // Check one accepted output beat against the oldest expectation
    task check_result(input result_t got);
      result_t want;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.operation != want.operation)
        report($sformatf("operation %0d, want %0d", got.operation, want.operation));
      if (got.name_length != want.name_length)
        report($sformatf("name_length %0d, want %0d", got.name_length, want.name_length));
      if (got.argument_length != want.argument_length)
        report($sformatf("argument_length %0d, want %0d", got.argument_length,
                         want.argument_length));
      if (got.payload_byte != want.payload_byte)
        report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
      if (got.payload_part != want.payload_part)
        report($sformatf("payload_part %0d, want %0d", got.payload_part, want.payload_part));
      if (got.last != want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic [7:0] rx_byte = 0;
  logic       in_valid = 0;
  logic       in_stall;
  logic [3:0] kind;
  logic [1:0] operation;
  logic [5:0] name_length;
  logic [5:0] argument_length;
  logic [7:0] payload_byte;
  logic [1:0] payload_part;
  logic       last;
  logic       out_valid;
  logic       out_stall = 1;

  at_command_line_parser #(.LINE_MAX(LINE_LEN)) dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  line_scoreboard sb = new();
  int  send_idle = 0;     // percent of cycles the sender idles
  int  recv_stall = 0;    // percent of cycles the receiver stalls
  bit  hold_off = 0;      // long receiver hold-off
  longint cycles = 0;
  byte unsigned line_q[$];

  // Count cycles and end the run at the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL at_command_line_parser");
      $finish;
    end
  end

  // Drive receiver stall and check accepted results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{kind_t'(kind), op_t'(operation), name_length, argument_length,
                        payload_byte, part_t'(payload_part), last});
    if (rst) out_stall <= 1;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall);
  end

  // Send one beat, idling first at random; valid stays up for a following beat
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    rx_byte <= b;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_text(input string s, input bit crlf = 1);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (crlf) begin send_byte(CH_CR); send_byte(CH_LF); end
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0: return CH_EQ;
      1: return CH_QM;
      2, 3: return 8'($urandom_range(8'h61, 8'h7A));
      4, 5: return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endcase
  endfunction

  // Random line: half AT+ commands with a name and suffix, the rest fixed commands and noise
  task automatic send_random_line();
    int n, sel;
    string pre;
    sel = $urandom_range(19);
    pre = ($urandom_range(1)) ? "AT+" : "at+";
    if (sel < 10) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 6);
      for (int i = 0; i < 3; i++) send_byte(pre[i]);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(8'h41, 8'h7A)) | 8'h00);
      case ($urandom_range(3))
        0: ;
        1: send_byte(CH_QM);
        2: begin send_byte(CH_EQ); send_byte(CH_QM); end
        default: begin
          send_byte(CH_EQ);
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) send_byte(rand_char());
        end
      endcase
    end else if (sel < 13) begin
      case ($urandom_range(5))
        0: send_text("aT", 0);
        1: send_text("Atz", 0);
        2: send_text("atZ?", 0);
        3: send_text("ATr", 0);
        4: send_text("atr?", 0);
        default: send_text("ATX", 0);
      endcase
    end else if (sel < 15) begin
      for (int i = 0; i < 3; i++) send_byte(pre[i]);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(rand_char());
    end else if (sel < 18) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(60, 70);
      for (int i = 0; i < n; i++) send_byte(rand_char());
    end
    case ($urandom_range(3))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      default: begin send_byte(CH_CR); send_byte(CH_LF); end
    endcase
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: fixed commands, suffixes, errors, edits, overflow
    send_text("AT"); send_text("atz"); send_text("ATZ?"); send_text("aTr");
    send_text("ATR?"); send_text("AT+ver"); send_text("AT+Ver?");
    send_text("at+band=?"); send_text("AT+key=a~b Z");
    send_text("AT+=1"); send_text("AT+x=?="); send_text("AT+x=a?b");
    send_text("AT+x="); send_text("hello");
    send_byte(CH_BS); send_byte(CH_DEL); send_byte(CH_CR); send_byte(CH_LF);
    send_byte(CH_LF);
    send_text(string'({"ATQ", 8'h08, 8'h01, 8'hFF, 8'h80, 8'h7E}));
    for (int i = 0; i < 66; i++) send_byte(CH_TILDE);
    send_byte(CH_CR);
    for (int i = 0; i < 63; i++) send_byte(i[0] ? CH_SPACE : 8'h5A);
    send_byte(CH_LF);
    drain();

    // Random phases with different sender idling and receiver stalling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 38) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 38) : 0;
      for (int i = 0; i < 2; i++) send_random_line();
      drain();
    end

    // Long hold-off: the block fills up and stalls its input
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 3; i++) send_text("at+abcdefgh=12345678");
    join
    drain();

    $display("covered %0d lines, %0d results checked, idle phases and a long hold-off",
             sb.n_lines, sb.n_results);
    if (errors == 0) $display("PASS at_command_line_parser");
    else $display("FAIL at_command_line_parser");
    $finish;
  end

endmodule
